FILE: design/sfm_pkg.sv
package sfm_pkg;
   localparam int unsigned WordWidth = 32;
   localparam int unsigned ExpWidth = 8;
   localparam int unsigned FracWidth = 23;
   localparam int unsigned SigWidth = 24;
   localparam int unsigned ProdWidth = 48;
   localparam int unsigned SumExpWidth = 10;
   localparam logic [ExpWidth-1:0] ExpMax = 8'd255;
   localparam logic [SumExpWidth-1:0] ExpBias = 10'd127;

   typedef struct packed {
      logic                   sign;
      logic [ExpWidth-1:0]    exp_a;
      logic [ExpWidth-1:0]    exp_b;
      logic [ProdWidth-1:0]   prod;
   } stage_type;
endpackage

FILE: design/sfm_mult.sv
module sfm_mult (
   input  logic [sfm_pkg::WordWidth-1:0] operand_a,
   input  logic [sfm_pkg::WordWidth-1:0] operand_b,
   output sfm_pkg::stage_type            stage
);
   logic [sfm_pkg::SigWidth-1:0] sig_a;
   logic [sfm_pkg::SigWidth-1:0] sig_b;

   assign sig_a = {1'b1, operand_a[sfm_pkg::FracWidth-1:0]};
   assign sig_b = {1'b1, operand_b[sfm_pkg::FracWidth-1:0]};

   always_comb begin
      stage.sign  = operand_a[31] ^ operand_b[31];
      stage.exp_a = operand_a[30:23];
      stage.exp_b = operand_b[30:23];
      stage.prod  = {{sfm_pkg::SigWidth{1'b0}}, sig_a} * {{sfm_pkg::SigWidth{1'b0}}, sig_b};
   end
endmodule

FILE: design/sfm_round.sv
module sfm_round (
   input  sfm_pkg::stage_type            stage,
   output logic [sfm_pkg::WordWidth-1:0] product
);
   logic                  top;
   logic [23:0]           kept;
   logic                  guard;
   logic                  sticky;
   logic                  up;
   logic [24:0]           rounded;
   logic                  carry;
   logic [9:0]            exp;
   logic                  special;

   always_comb begin
      top = stage.prod[47];
      if (top) begin
         kept   = stage.prod[47:24];
         guard  = stage.prod[23];
         sticky = |stage.prod[22:0];
      end else begin
         kept   = stage.prod[46:23];
         guard  = stage.prod[22];
         sticky = |stage.prod[21:0];
      end
      up      = (guard & kept[0]) | sticky;
      rounded = {1'b0, kept} + {24'd0, up};
      carry   = rounded[24];
      exp     = {2'b00, stage.exp_a} + {2'b00, stage.exp_b} - sfm_pkg::ExpBias
              + {9'd0, top} + {9'd0, carry};
      special = (stage.exp_a == sfm_pkg::ExpMax) || (stage.exp_b == sfm_pkg::ExpMax);
      product = {stage.sign, exp[7:0], rounded[22:0]};
      if (!special) begin
         // exp is at most 2*255-127+2, so bit 9 marks negative
         if (exp[9] || exp == 10'd0) begin
            product = {stage.sign, 31'd0};
         end else if (exp >= {2'b00, sfm_pkg::ExpMax}) begin
            product = {stage.sign, sfm_pkg::ExpMax, 23'd0};
         end
      end
   end
endmodule

FILE: design/single_float_multiplier_top.sv
// channel | direction | ports
// req     | in        | req_valid, req_ready, req_operand_a, req_operand_b
// rsp     | out       | rsp_valid, rsp_ready, rsp_product
// two register stages: operands to stage register (multiply), then rounding to result
// register; one item per cycle while the result register is empty or rsp_ready is high.
// reset clears the valid bits only.
// a stall holds the full stages; each stage takes new data when it is empty or moves on.
module single_float_multiplier_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_product
);
   sfm_pkg::stage_type stage_in;
   sfm_pkg::stage_type stage_ff;
   logic               stage_valid_ff;
   logic [31:0]        product_in;
   logic [31:0]        product_ff;
   logic               out_valid_ff;
   logic               out_move;
   logic               stage_move;

   sfm_mult u_mult (
      .operand_a(req_operand_a),
      .operand_b(req_operand_b),
      .stage    (stage_in)
   );

   sfm_round u_round (
      .stage  (stage_ff),
      .product(product_in)
   );

   assign out_move   = !out_valid_ff || rsp_ready;
   assign stage_move = !stage_valid_ff || out_move;
   assign req_ready  = stage_move;
   assign rsp_valid  = out_valid_ff;
   assign rsp_product = product_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (stage_move) begin
            stage_valid_ff <= req_valid;
         end
         if (out_move) begin
            out_valid_ff <= stage_valid_ff;
         end
      end
      if (stage_move && req_valid) begin
         stage_ff <= stage_in;
      end
      if (out_move && stage_valid_ff) begin
         product_ff <= product_in;
      end
   end
endmodule
